[rtl/ped_pkg.sv]
// ped_pkg: shared constants, types and hex-digit helper for the percent
// escape decoder. No dependencies.
package ped_pkg;

  localparam int unsigned CharW = 8;

  // Escape tracking phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;  // no escape pending
  localparam logic [1:0] PH_PCT   = 2'd1;  // '%' seen
  localparam logic [1:0] PH_DIGIT = 2'd2;  // '%' and first digit seen

  localparam logic [CharW-1:0] CH_PERCENT = 8'h25;
  localparam logic [CharW-1:0] CH_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CH_NINE    = 8'h39;
  localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] ALPHA_BIAS = 8'd55;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_nib_t;

  typedef struct packed {
    logic [CharW-1:0] data;
    logic             last;
  } beat_t;

  // Uppercase hex only; val is zero when ok is low.
  function automatic hex_nib_t hex_decode(input logic [CharW-1:0] c);
    hex_nib_t         h;
    logic [CharW-1:0] d;
    h = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d     = c - CH_ZERO;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d     = c - ALPHA_BIAS;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

endpackage

[rtl/percent_escape_decoder_unit.sv]
// percent_escape_decoder_unit: URL-style percent-escape decoder, one
// character per transfer. Depends on ped_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------
//  in_     | in  | in_tvalid/tready   | tdata = char[7:0], tlast = last
//  out_    | out | out_tvalid/tready  | tdata = byte[7:0], tlast = last
//
// One character transfer per cycle sustained while the queue has room; a
// character passes the input register, then the two-entry result queue,
// on its way out. A '%' followed by only one character yields two
// results; while the output drains every cycle the queue absorbs them with
// no input stall. With out_tready low the queue fills and the input holds
// until there is room. Reset (rst_n low, synchronous) clears the valid
// flags, queue count, escape phase and partial byte.
module percent_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  // Input register
  logic                       in_vld_r;
  logic [ped_pkg::CharW-1:0]  in_char_r;
  logic                       in_last_r;

  // Escape state
  logic [1:0]                 phase_r, phase_nxt;
  logic [ped_pkg::CharW-1:0]  partial_r, partial_nxt;

  // Result queue, two entries, head in q0
  ped_pkg::beat_t             q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;

  // Decode results for the registered character
  ped_pkg::beat_t             res0, res1;
  logic [1:0]                 n_res;
  ped_pkg::hex_nib_t          hex;

  logic                       pop, consume;
  logic [1:0]                 sh_cnt;
  logic [2:0]                 fill;

  assign hex = ped_pkg::hex_decode(in_char_r);

  // Single-pass escape decode
  always_comb begin
    res0        = '{data: in_char_r, last: in_last_r};
    res1        = '{data: in_char_r, last: 1'b1};
    n_res       = 2'd1;
    phase_nxt   = ped_pkg::PH_IDLE;
    partial_nxt = partial_r;
    unique case (phase_r)
      ped_pkg::PH_PCT: begin
        if (in_last_r) begin
          // percent with a single trailing character: flush both
          res0  = '{data: ped_pkg::CH_PERCENT, last: 1'b0};
          n_res = 2'd2;
        end else begin
          n_res       = 2'd0;
          phase_nxt   = ped_pkg::PH_DIGIT;
          partial_nxt = hex.ok ? {hex.val, 4'h0} : ped_pkg::CH_SPACE;
        end
      end
      ped_pkg::PH_DIGIT: begin
        res0        = '{data: partial_r | {4'h0, hex.val}, last: in_last_r};
        partial_nxt = '0;
      end
      default: begin
        // idle (and the unused code): open an escape unless string ends here
        if (in_char_r == ped_pkg::CH_PERCENT && !in_last_r) begin
          n_res     = 2'd0;
          phase_nxt = ped_pkg::PH_PCT;
        end
      end
    endcase
  end

  // Queue room check and update
  assign pop     = out_tvalid && out_tready;
  assign sh_cnt  = cnt_r - {1'b0, pop};
  assign fill    = {1'b0, sh_cnt} + {1'b0, n_res};
  assign consume = in_vld_r && (fill <= 3'd2);
  assign in_tready = !in_vld_r || consume;

  always_comb begin
    q0_nxt  = pop ? q1_r : q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = sh_cnt;
    if (consume) begin
      cnt_nxt = fill[1:0];
      if (n_res != 2'd0) begin
        if (sh_cnt == 2'd0) begin
          q0_nxt = res0;
          q1_nxt = res1;
        end else begin
          q1_nxt = res0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      cnt_r     <= 2'd0;
      phase_r   <= ped_pkg::PH_IDLE;
      partial_r <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      cnt_r <= cnt_nxt;
      if (consume) begin
        phase_r   <= phase_nxt;
        partial_r <= partial_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q0_r.data;
  assign out_tlast  = q0_r.last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue overfilled");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("unused escape phase reached");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |=> phase_r == ped_pkg::PH_IDLE)
    else $error("escape left pending at end of string");

  a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
    consume && n_res == 2'd2 |-> sh_cnt == 2'd0)
    else $error("two results taken without room");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !consume |=> in_vld_r && $stable(in_char_r))
    else $error("held character lost");
`endif

endmodule

[bench/ped_checker.sv]
// ped_checker: watches both channels of the percent escape decoder, predicts
// the decoded byte stream and compares each output transfer with it.
// Depends on ped_pkg for the phase codes, character constants and beat_t.
module ped_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  output int         mismatch_count,
  output int         expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 30;

  logic [1:0]     esc_phase = ped_pkg::PH_IDLE;
  logic [7:0]     esc_high  = '0;
  ped_pkg::beat_t decoded_q[$];
  int             errors    = 0;
  int             left_n    = 0;

  assign mismatch_count = errors;
  assign expected_left  = left_n;

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Uppercase hex only. Digits carry their value in the low nibble,
  // letters A-F sit at 1-6 in the low nibble.
  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'h0;
    if (c >= ped_pkg::CH_ZERO && c <= ped_pkg::CH_NINE) begin
      nib = c[3:0];
      return 1'b1;
    end
    if (c >= ped_pkg::CH_UPPER_A && c <= ped_pkg::CH_UPPER_F) begin
      nib = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l);
    decoded_q.push_back('{data: b, last: l});
  endtask

  task automatic predict_char(input logic [7:0] c, input logic l);
    logic [3:0] nib;
    logic       ok;
    ok = hex_digit(c, nib);
    case (esc_phase)
      ped_pkg::PH_PCT: begin
        if (l) begin
          // string ends on the character right after the percent: flush both as they came
          push_byte(ped_pkg::CH_PERCENT, 1'b0);
          push_byte(c, 1'b1);
          esc_phase = ped_pkg::PH_IDLE;
        end else begin
          esc_high  = ok ? {nib, 4'h0} : ped_pkg::CH_SPACE;
          esc_phase = ped_pkg::PH_DIGIT;
        end
      end
      ped_pkg::PH_DIGIT: begin
        push_byte(esc_high | (ok ? {4'h0, nib} : 8'h00), l);
        esc_phase = ped_pkg::PH_IDLE;
        esc_high  = '0;
      end
      default: begin
        if (c == ped_pkg::CH_PERCENT && !l) begin
          esc_phase = ped_pkg::PH_PCT;
        end else begin
          push_byte(c, l);
          esc_phase = ped_pkg::PH_IDLE;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    ped_pkg::beat_t want;
    if (!rst_n) begin
      esc_phase = ped_pkg::PH_IDLE;
      esc_high  = '0;
      decoded_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data)
            report_mismatch($sformatf("byte %02h, want %02h", out_tdata, want.data));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                      out_tlast, want.last, want.data));
        end
      end
    end
    left_n <= decoded_q.size();
  end

endmodule

[bench/percent_escape_decoder_unit_tb.sv]
// percent_escape_decoder_unit_tb: drives strings of characters into the
// decoder with bursty input and switching output stall modes, and gives the verdict.
// Depends on ped_pkg, percent_escape_decoder_unit and ped_checker.
module percent_escape_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part stops once this many characters went in.
  localparam int RandomChars = 1050;
  // Keep a wide margin over the slowest correct run.
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 12;

  // Receiver stall modes, picked anew at random by the backpressure block
  localparam logic [1:0] RX_FREE  = 2'd0;  // always ready
  localparam logic [1:0] RX_COIN  = 2'd1;  // ready half the time
  localparam logic [1:0] RX_CHOKE = 2'd2;  // ready with a one-in-five chance
  localparam logic [1:0] RX_BEAT  = 2'd3;  // ready follows bit 2 of the cycle counter, inverted

  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [7:0] in_char
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tlast;

  int         mismatch_count;
  int         expected_left;
  int         cycle_cnt  = 0;
  int         burst_left = 0;
  int         sent       = 0;
  logic [1:0] rx_mode    = RX_FREE;

  percent_escape_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ped_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .expected_left  (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side backpressure. The mode is picked anew whenever bits 6:0 of
  // the cycle counter are zero, so stalls land on every phase of an escape, including the two-byte flush.
  always @(posedge clk) begin
    if (cycle_cnt[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_tready <= ($urandom_range(0, 4) == 0);
      default:  out_tready <= ~cycle_cnt[2];
    endcase
  end

  // One character transfer. Called at a rising edge; returns at the edge
  // where the transfer happened. Bursts of 1-24 characters, sometimes
  // back to back with no gap at all.
  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Escape digit candidate: mostly valid uppercase hex, with lowercase,
  // a stray percent and arbitrary bytes mixed in.
  function automatic logic [7:0] pick_digit();
    int r;
    r = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return (r < 10) ? ped_pkg::CH_ZERO + 8'(r)
                                        : ped_pkg::CH_UPPER_A + 8'(r - 10);
      6:                return CH_LOWER_A + 8'($urandom_range(0, 5));
      7:                return ped_pkg::CH_PERCENT;
      default:          return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_string();
    logic [7:0] str[$];
    int         len;
    int         cut;
    len = $urandom_range(1, 16);
    if ($urandom_range(0, 7) == 0) begin
      // noise: raw bytes, escapes only by chance
      repeat (len) str.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (str.size() < len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            str.push_back(ped_pkg::CH_PERCENT);
            str.push_back(pick_digit());
            str.push_back(pick_digit());
          end
          4:       str.push_back(ped_pkg::CH_PERCENT);
          default: str.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      // a third of the strings may get chopped by one or two characters, some ending on a pending escape
      if ($urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, 2);
        if (str.size() > cut) repeat (cut) void'(str.pop_back());
      end
    end
    foreach (str[i]) begin
      send_char(str[i], i == str.size() - 1);
      sent++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: character extremes, then the escape corner cases
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("%41");   // escape completed by the last character
    send_text("%");     // percent as the last character
    send_text("%Z");    // percent with one character after it
    send_text("%%9");   // percent in a digit position is just a non-hex digit
    send_text("%Fa");   // lowercase second digit adds nothing
    send_text("%a0");   // lowercase first digit gives the space high part
    send_text("%0Fx");  // escape then a plain character
    send_text("%G/");   // just past the hex ranges on both sides

    while (sent < RandomChars) send_random_string();
    in_tvalid <= 1'b0;

    // wait so the count includes the bytes of the final transfer
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && expected_left == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ped_pkg.sv
rtl/percent_escape_decoder_unit.sv
bench/ped_checker.sv
bench/percent_escape_decoder_unit_tb.sv
